// ----- design/rmq_pkg.sv -----
// Shared constants and types for the rotation matrix to quaternion block.
package rmq_pkg;
    localparam int FracBitsDefault = 14;
    localparam int ElemW = 16;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_ROW1  = 2'd1,
        BR_ROW2  = 2'd2,
        BR_ROW3  = 2'd3
    } branch_t;
endpackage

// ----- design/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt import rmq_pkg::*; #(
    parameter int InW  = 36,
    parameter int TagW = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [InW-1:0]        in_arg,
    input  logic [TagW-1:0]       in_tag,
    output logic                  out_valid,
    output logic [(InW+1)/2-1:0]  out_root,
    output logic [TagW-1:0]       out_tag
);
    localparam int RootW = (InW + 1) / 2;
    localparam int ArgW  = 2 * RootW;

    logic [RootW:0]             valid_reg;
    logic [ArgW-1:0]            arg_reg  [RootW+1];
    logic [RootW+1:0]           rem_reg  [RootW+1];
    logic [RootW-1:0]           root_reg [RootW+1];
    logic [TagW-1:0]            tag_reg  [RootW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[RootW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            arg_reg[0]  <= ArgW'(in_arg);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
        end
    end

    // Each stage brings down two argument bits and decides one root bit.
    for (genvar k = 0; k < RootW; k++) begin : g_stage
        logic [RootW+1:0] rem_sh;
        logic [RootW+1:0] trial;
        always_comb begin
            rem_sh = {rem_reg[k][RootW-1:0], arg_reg[k][ArgW-1:ArgW-2]};
            trial  = {root_reg[k], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                arg_reg[k+1] <= {arg_reg[k][ArgW-3:0], 2'b00};
                tag_reg[k+1] <= tag_reg[k];
                if (rem_sh >= trial) begin
                    rem_reg[k+1]  <= rem_sh - trial;
                    root_reg[k+1] <= {root_reg[k][RootW-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= rem_sh;
                    root_reg[k+1] <= {root_reg[k][RootW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[RootW];
    assign out_root  = root_reg[RootW];
    assign out_tag   = tag_reg[RootW];
endmodule

// ----- design/rmq_div.sv -----
// Pipelined restoring divider on magnitudes, up to (NumW + QW - 1) / QW numerator bits per stage.
module rmq_div import rmq_pkg::*; #(
    parameter int NumW = 32,
    parameter int DenW = 16,
    parameter int QW   = 20
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NumW-1:0]  in_num,
    input  logic [DenW-1:0]  in_den,
    output logic [QW-1:0]    out_quo
);
    // A quotient that overflows QW bits is replaced by 2^(QW-1); the caller saturates further.
    localparam int RemW = DenW + 1;

    logic [NumW-1:0] num_reg [QW+1];
    logic [DenW-1:0] den_reg [QW+1];
    logic [RemW-1:0] rem_reg [QW+1];
    logic [QW-1:0]   quo_reg [QW+1];
    logic            ovf_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= in_num;
            den_reg[0] <= in_den;
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            ovf_reg[0] <= 1'b0;
        end
    end

    // Stages walk numerator bits from the top; quotient bits above QW set overflow.
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int Bits = (NumW + QW - 1) / QW;
        logic [RemW-1:0] r;
        logic [QW-1:0]   q;
        logic            o;
        logic [NumW-1:0] n;
        always_comb begin
            r = rem_reg[k];
            q = quo_reg[k];
            o = ovf_reg[k];
            n = num_reg[k];
            for (int b = 0; b < Bits; b++) begin
                if ((k * Bits + b) < NumW) begin
                    r = {r[RemW-2:0], n[NumW-1]};
                    n = {n[NumW-2:0], 1'b0};
                    o = o | q[QW-1];
                    q = {q[QW-2:0], 1'b0};
                    if (r >= RemW'(den_reg[k])) begin
                        r = r - RemW'(den_reg[k]);
                        q[0] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k+1] <= n;
                den_reg[k+1] <= den_reg[k];
                rem_reg[k+1] <= r;
                quo_reg[k+1] <= q;
                ovf_reg[k+1] <= o;
            end
        end
    end

    assign out_quo = ovf_reg[QW] ? {1'b1, {(QW-1){1'b0}}} : quo_reg[QW];
endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
// Top level: rotation matrix to quaternion conversion pipeline.
// Usage:
// The s_ channel takes one 3x3 matrix per request as nine signed Q2.14 elements
// packed in s_tdata, element row 1 column 1 lowest. The m_ channel returns the
// quaternion w, x, y, z in Q2.14 in m_tdata and the branch and degenerate flag
// in m_tuser. One request enters per clock and one result leaves per clock while m_tready does not stall the output.
// At the default FRAC_BITS of 14 the stages are the branch and root argument
// register, the square root (an input register and one stage per root bit, 19
// in all), a register holding the root, the divider (an input register and 24
// stages of up to two numerator bits each) and a rounding and saturation stage.
// The four divisions run side by side.
// The whole pipeline advances only when its output register is free or being
// emptied, so a stall on m_tready freezes every stage and loses nothing;
// s_tready follows that same condition.
// Synchronous active-low reset clears all valid bits; data registers are not
// reset.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // e_r1c1, e_r1c2, e_r1c3, e_r2c1, e_r2c2, e_r2c3, e_r3c1, e_r3c2, e_r3c3
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [63:0]  m_tdata,
    // branch_taken, degenerate
    output logic [2:0]   m_tuser
);
    // Signed root argument; it must hold one plus three element sums.
    localparam int ArgW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int SqW   = ArgW + FRAC_BITS + 2;
    localparam int RootW = (SqW + 1) / 2;
    localparam int DW    = 18;                    // magnitude of a difference
    localparam int NumW  = DW + FRAC_BITS + 1;
    localparam int QW    = 24;
    localparam int TagW  = 2 + 4 + 4 * DW;

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Stage 1: branch choice, root argument and the three element differences or sums.
    logic signed [17:0] m [9];
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i] = 18'(signed'(s_tdata[16*i +: 16]));
        end
    end

    logic               v1_reg;
    logic [ArgW-1:0]    arg1_reg;
    logic [1:0]         br1_reg;
    logic [3:0]         neg1_reg;
    logic [DW-1:0]      mag1_reg [4];

    branch_t        s1_br;
    logic [ArgW-1:0] s1_arg;
    logic [3:0]     s1_neg;
    logic [DW-1:0]  s1_mag [4];

    always_comb begin : blk_s1
        logic signed [ArgW-1:0] tr, a;
        logic signed [18:0] d [4];
        branch_t br;
        tr = ArgW'(m[0]) + ArgW'(m[4]) + ArgW'(m[8]);
        d[0] = '0; d[1] = '0; d[2] = '0; d[3] = '0;
        if (tr > 0) begin
            br = BR_TRACE;
            a = tr + ArgW'(1 << FRAC_BITS);
            d[1] = 19'(m[7]) - 19'(m[5]);
            d[2] = 19'(m[2]) - 19'(m[6]);
            d[3] = 19'(m[3]) - 19'(m[1]);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            br = BR_ROW1;
            a = ArgW'(1 << FRAC_BITS) + ArgW'(m[0]) - ArgW'(m[4]) - ArgW'(m[8]);
            d[0] = 19'(m[7]) - 19'(m[5]);
            d[2] = 19'(m[1]) + 19'(m[3]);
            d[3] = 19'(m[2]) + 19'(m[6]);
        end else if (m[4] > m[8]) begin
            br = BR_ROW2;
            a = ArgW'(1 << FRAC_BITS) + ArgW'(m[4]) - ArgW'(m[0]) - ArgW'(m[8]);
            d[0] = 19'(m[2]) - 19'(m[6]);
            d[1] = 19'(m[1]) + 19'(m[3]);
            d[3] = 19'(m[5]) + 19'(m[7]);
        end else begin
            br = BR_ROW3;
            a = ArgW'(1 << FRAC_BITS) + ArgW'(m[8]) - ArgW'(m[0]) - ArgW'(m[4]);
            d[0] = 19'(m[3]) - 19'(m[1]);
            d[1] = 19'(m[2]) + 19'(m[6]);
            d[2] = 19'(m[5]) + 19'(m[7]);
        end
        s1_br   = br;
        s1_arg  = a[ArgW-1] ? '0 : ArgW'(a);
        for (int i = 0; i < 4; i++) begin
            s1_neg[i] = d[i][18];
            s1_mag[i] = d[i][18] ? DW'(-d[i]) : DW'(d[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            arg1_reg <= s1_arg;
            br1_reg  <= s1_br;
            neg1_reg <= s1_neg;
            for (int i = 0; i < 4; i++) begin
                mag1_reg[i] <= s1_mag[i];
            end
        end
    end

    // Square root of A * 2^(FRAC_BITS+2), tag carries the rest.
    logic [TagW-1:0] tag_in, tag_out;
    logic            v2;
    logic [RootW-1:0] root;
    assign tag_in = {mag1_reg[3], mag1_reg[2], mag1_reg[1], mag1_reg[0], neg1_reg, br1_reg};

    rmq_sqrt #(.InW(SqW), .TagW(TagW)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .in_arg    ({arg1_reg, {(FRAC_BITS+2){1'b0}}}),
        .in_tag    (tag_in),
        .out_valid (v2),
        .out_root  (root),
        .out_tag   (tag_out)
    );

    // Register after the root: divisor plus half-divisor rounding term.
    localparam int SW = RootW;
    logic           v3_reg;
    logic [SW-1:0]  s3_reg;
    logic [TagW-1:0] tag3_reg;
    logic [NumW-1:0] num3 [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg   <= SW'(root);
            tag3_reg <= tag_out;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num3[i] = (NumW'(tag3_reg[6 + DW*i +: DW]) << FRAC_BITS)
                      + NumW'(s3_reg >> 1);
        end
    end

    // Delay line for control alongside the divider.
    localparam int DivLat = QW + 1;
    logic [DivLat-1:0] vd_reg;
    logic [SW-1:0]     sd_reg  [DivLat];
    logic [5:0]        ctl_reg [DivLat];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= '0;
        end else if (en) begin
            vd_reg <= {vd_reg[DivLat-2:0], v3_reg};
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0]  <= s3_reg;
            ctl_reg[0] <= tag3_reg[5:0];
            for (int i = 1; i < DivLat; i++) begin
                sd_reg[i]  <= sd_reg[i-1];
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    logic [QW-1:0] quo [4];
    for (genvar g = 0; g < 4; g++) begin : g_div
        rmq_div #(.NumW(NumW), .DenW(SW), .QW(QW)) u_div (
            .aclk    (aclk),
            .en      (en),
            .in_num  (num3[g]),
            .in_den  (s3_reg),
            .out_quo (quo[g])
        );
    end

    // The divider output lines up with the last delay stage.
    logic [SW-1:0] sf;
    logic [5:0]    ctlf;
    assign sf   = sd_reg[DivLat-1];
    assign ctlf = ctl_reg[DivLat-1];

    logic [63:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic [63:0] data_next;

    always_comb begin : blk_out
        logic [15:0] c;
        logic [SW:0] piv;
        piv = ({1'b0, sf} + (SW+1)'(2)) >> 2;
        for (int i = 0; i < 4; i++) begin
            if (ctlf[2 + i]) begin
                c = (quo[i] > QW'(32768)) ? 16'h8000 : 16'(-quo[i]);
            end else begin
                c = (quo[i] > QW'(32767)) ? 16'h7fff : quo[i][15:0];
            end
            if (2'(i) == ctlf[1:0]) begin
                c = (piv > (SW+1)'(32767)) ? 16'h7fff : piv[15:0];
            end
            if (sf == '0) begin
                c = '0;
            end
            data_next[16*i +: 16] = c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vd_reg[DivLat-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= data_next;
            out_user_reg <= {(sf == '0), ctlf[1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
endmodule
